// File: hw/rtl/pfr_pkg.sv
// ----------------------------------------------------------------------------
// pfr_pkg: shared types and constants for the format respeller
// Parse phases and the character codes that the parser recognises.
// ----------------------------------------------------------------------------
package pfr_pkg;

  localparam int CHAR_W = 16;

  typedef enum logic [3:0] {
    PH_LIT,
    PH_PCT,
    PH_FLAGS,
    PH_WIDTH,
    PH_PREC,
    PH_LEN,
    PH_HI,
    PH_HI6,
    PH_HI3,
    PH_CONV
  } phase_t;

  localparam logic [7:0] CH_UPPER_S = 8'h53;
  localparam logic [7:0] CH_UPPER_C = 8'h43;
  localparam logic [7:0] CH_LOWER_S = 8'h73;
  localparam logic [7:0] CH_LOWER_C = 8'h63;
  localparam logic [7:0] CH_W       = 8'h77;
  localparam logic [7:0] CH_L       = 8'h6C;
  localparam logic [7:0] CH_UPPER_L = 8'h4C;
  localparam logic [7:0] CH_H       = 8'h68;
  localparam logic [7:0] CH_J       = 8'h6A;
  localparam logic [7:0] CH_Z       = 8'h7A;
  localparam logic [7:0] CH_T       = 8'h74;
  localparam logic [7:0] CH_I       = 8'h49;
  localparam logic [7:0] CH_6       = 8'h36;
  localparam logic [7:0] CH_4       = 8'h34;
  localparam logic [7:0] CH_3       = 8'h33;
  localparam logic [7:0] CH_2       = 8'h32;
  localparam logic [7:0] CH_0       = 8'h30;
  localparam logic [7:0] CH_9       = 8'h39;
  localparam logic [7:0] CH_PCT     = 8'h25;
  localparam logic [7:0] CH_DOT     = 8'h2E;
  localparam logic [7:0] CH_STAR    = 8'h2A;
  localparam logic [7:0] CH_APOS    = 8'h27;
  localparam logic [7:0] CH_MINUS   = 8'h2D;
  localparam logic [7:0] CH_PLUS    = 8'h2B;
  localparam logic [7:0] CH_SPACE   = 8'h20;
  localparam logic [7:0] CH_HASH    = 8'h23;

endpackage

// File: hw/rtl/pfr_front.sv
// ----------------------------------------------------------------------------
// pfr_front: format parser
// Classifies each accepted character, holds length modifiers and produces a
// group of output characters, with an optional terminator, for the back end.
// ----------------------------------------------------------------------------
module pfr_front #(
  parameter int MAX_LEN = 3,
  parameter int CW      = 16
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 wide_mode,
  input  logic                                 acc,
  input  logic [pfr_pkg::CHAR_W-1:0]           in_char,
  input  logic                                 in_last,
  output logic                                 desc_valid,
  output logic [((MAX_LEN > 2) ? MAX_LEN : 2) * CW + CW
               + $clog2(((MAX_LEN > 2) ? MAX_LEN : 2) + 2) : 0] desc
);

  localparam int NHELD = (MAX_LEN > 2) ? MAX_LEN : 2;
  localparam int NSLOT = NHELD + 1;
  localparam int CNTW  = $clog2(NHELD + 1);
  localparam int NW    = $clog2(NSLOT + 1);

  function automatic logic eq(input logic [CW-1:0] a, input logic [7:0] k);
    return a == CW'(k);
  endfunction

  pfr_pkg::phase_t phase, phase_next;
  logic [CNTW-1:0] cnt, cnt_next, conv_cnt;
  logic [7:0] mods [NHELD];
  logic [7:0] mods_next [NHELD];
  logic [NSLOT-1:0][CW-1:0] chs;
  logic [NW-1:0] n;
  logic term;
  logic [CW-1:0] c;
  logic is_flag, is_width, is_length;
  logic flags_path, width_path, len_start, do_conv, lit_phase;
  logic [7:0] first;
  logic wide_arg, sc_conv;

  assign c = in_char[CW-1:0];

  assign is_flag = eq(c, pfr_pkg::CH_MINUS) || eq(c, pfr_pkg::CH_PLUS) ||
                   eq(c, pfr_pkg::CH_SPACE) || eq(c, pfr_pkg::CH_HASH) ||
                   eq(c, pfr_pkg::CH_0) || eq(c, pfr_pkg::CH_APOS);
  assign is_width = (c >= CW'(pfr_pkg::CH_0) && c <= CW'(pfr_pkg::CH_9)) ||
                    eq(c, pfr_pkg::CH_STAR);
  assign is_length = eq(c, pfr_pkg::CH_H) || eq(c, pfr_pkg::CH_L) ||
                     eq(c, pfr_pkg::CH_UPPER_L) || eq(c, pfr_pkg::CH_J) ||
                     eq(c, pfr_pkg::CH_Z) || eq(c, pfr_pkg::CH_T) ||
                     eq(c, pfr_pkg::CH_W);

  always_comb begin
    phase_next = phase;
    cnt_next   = cnt;
    mods_next  = mods;
    chs        = '0;
    n          = '0;
    term       = 1'b0;
    flags_path = 1'b0;
    width_path = 1'b0;
    len_start  = 1'b0;
    do_conv    = 1'b0;
    lit_phase  = 1'b0;
    conv_cnt   = cnt;
    first      = '0;
    wide_arg   = 1'b0;
    sc_conv    = 1'b0;
    if (acc) begin
      unique case (phase)
        pfr_pkg::PH_LIT: begin
          chs[0]    = c;
          n         = NW'(1);
          lit_phase = 1'b1;
        end
        pfr_pkg::PH_PCT: begin
          if (eq(c, pfr_pkg::CH_PCT)) begin
            chs[0]     = c;
            n          = NW'(1);
            phase_next = pfr_pkg::PH_LIT;
          end else begin
            flags_path = 1'b1;
          end
        end
        pfr_pkg::PH_FLAGS: flags_path = 1'b1;
        pfr_pkg::PH_WIDTH: width_path = 1'b1;
        pfr_pkg::PH_PREC: begin
          if (is_width) begin
            chs[0] = c;
            n      = NW'(1);
          end else begin
            len_start = 1'b1;
          end
        end
        pfr_pkg::PH_LEN: begin
          if (cnt < CNTW'(MAX_LEN) && is_length) begin
            for (int i = 0; i < NHELD; i++) begin
              if (CNTW'(i) == cnt) begin
                mods_next[i] = c[7:0];
              end
            end
            cnt_next = cnt + CNTW'(1);
          end else begin
            do_conv = 1'b1;
          end
        end
        pfr_pkg::PH_HI: begin
          if (eq(c, pfr_pkg::CH_6)) begin
            phase_next = pfr_pkg::PH_HI6;
          end else if (eq(c, pfr_pkg::CH_3)) begin
            phase_next = pfr_pkg::PH_HI3;
          end else begin
            chs[0]    = CW'(pfr_pkg::CH_I);
            chs[1]    = c;
            n         = NW'(2);
            lit_phase = 1'b1;
          end
        end
        pfr_pkg::PH_HI6: begin
          if (eq(c, pfr_pkg::CH_4)) begin
            mods_next[0] = pfr_pkg::CH_L;
            mods_next[1] = pfr_pkg::CH_L;
            cnt_next     = CNTW'(2);
            phase_next   = pfr_pkg::PH_CONV;
          end else begin
            chs[0]    = CW'(pfr_pkg::CH_I);
            chs[1]    = CW'(pfr_pkg::CH_6);
            chs[2]    = c;
            n         = NW'(3);
            lit_phase = 1'b1;
          end
        end
        pfr_pkg::PH_HI3: begin
          if (eq(c, pfr_pkg::CH_2)) begin
            cnt_next   = '0;
            phase_next = pfr_pkg::PH_CONV;
          end else begin
            chs[0]    = CW'(pfr_pkg::CH_I);
            chs[1]    = CW'(pfr_pkg::CH_3);
            chs[2]    = c;
            n         = NW'(3);
            lit_phase = 1'b1;
          end
        end
        pfr_pkg::PH_CONV: do_conv = 1'b1;
        default: begin
          chs[0]    = c;
          n         = NW'(1);
          lit_phase = 1'b1;
        end
      endcase

      if (flags_path) begin
        if (is_flag) begin
          chs[0]     = c;
          n          = NW'(1);
          phase_next = pfr_pkg::PH_FLAGS;
        end else begin
          width_path = 1'b1;
        end
      end

      if (width_path) begin
        if (is_width) begin
          chs[0]     = c;
          n          = NW'(1);
          phase_next = pfr_pkg::PH_WIDTH;
        end else if (eq(c, pfr_pkg::CH_DOT)) begin
          chs[0]     = c;
          n          = NW'(1);
          phase_next = pfr_pkg::PH_PREC;
        end else begin
          len_start = 1'b1;
        end
      end

      if (len_start) begin
        cnt_next = '0;
        if (eq(c, pfr_pkg::CH_I)) begin
          phase_next = pfr_pkg::PH_HI;
        end else if (is_length) begin
          mods_next[0] = c[7:0];
          cnt_next     = CNTW'(1);
          phase_next   = pfr_pkg::PH_LEN;
        end else begin
          do_conv  = 1'b1;
          conv_cnt = '0;
        end
      end

      if (lit_phase) begin
        phase_next = eq(c, pfr_pkg::CH_PCT) ? pfr_pkg::PH_PCT : pfr_pkg::PH_LIT;
      end

      if (do_conv) begin
        first = (conv_cnt != '0) ? mods[0] : 8'h00;
        if (eq(c, pfr_pkg::CH_UPPER_S) || eq(c, pfr_pkg::CH_UPPER_C)) begin
          sc_conv  = 1'b1;
          wide_arg = !wide_mode;
        end else if (eq(c, pfr_pkg::CH_LOWER_S) || eq(c, pfr_pkg::CH_LOWER_C)) begin
          sc_conv = 1'b1;
          if (first == pfr_pkg::CH_H) begin
            wide_arg = 1'b0;
          end else if (first == pfr_pkg::CH_L || first == pfr_pkg::CH_W) begin
            wide_arg = 1'b1;
          end else begin
            wide_arg = wide_mode;
          end
        end
        if (sc_conv) begin
          if (wide_arg) begin
            chs[0] = CW'(pfr_pkg::CH_L);
            chs[1] = (eq(c, pfr_pkg::CH_UPPER_S) || eq(c, pfr_pkg::CH_LOWER_S)) ?
                     CW'(pfr_pkg::CH_LOWER_S) : CW'(pfr_pkg::CH_LOWER_C);
            n      = NW'(2);
          end else begin
            chs[0] = (eq(c, pfr_pkg::CH_UPPER_S) || eq(c, pfr_pkg::CH_LOWER_S)) ?
                     CW'(pfr_pkg::CH_LOWER_S) : CW'(pfr_pkg::CH_LOWER_C);
            n      = NW'(1);
          end
        end else begin
          for (int i = 0; i < NHELD; i++) begin
            if (CNTW'(i) < conv_cnt) begin
              chs[i] = (mods[i] == pfr_pkg::CH_W) ? CW'(pfr_pkg::CH_L) : CW'(mods[i]);
            end
          end
          for (int i = 0; i < NSLOT; i++) begin
            if (NW'(i) == NW'(conv_cnt)) begin
              chs[i] = c;
            end
          end
          n = NW'(conv_cnt) + NW'(1);
        end
        phase_next = pfr_pkg::PH_LIT;
        cnt_next   = '0;
      end

      if (in_last) begin
        unique case (phase_next)
          pfr_pkg::PH_HI: begin
            chs[0] = CW'(pfr_pkg::CH_I);
            n      = NW'(1);
          end
          pfr_pkg::PH_HI6: begin
            chs[0] = CW'(pfr_pkg::CH_I);
            chs[1] = CW'(pfr_pkg::CH_6);
            n      = NW'(2);
          end
          pfr_pkg::PH_HI3: begin
            chs[0] = CW'(pfr_pkg::CH_I);
            chs[1] = CW'(pfr_pkg::CH_3);
            n      = NW'(2);
          end
          pfr_pkg::PH_LEN, pfr_pkg::PH_CONV: begin
            for (int i = 0; i < NHELD; i++) begin
              if (CNTW'(i) < cnt_next) begin
                chs[i] = CW'(mods_next[i]);
              end
            end
            n = NW'(cnt_next);
          end
          default: begin
          end
        endcase
        term       = 1'b1;
        phase_next = pfr_pkg::PH_LIT;
        cnt_next   = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= pfr_pkg::PH_LIT;
      cnt   <= '0;
    end else begin
      phase <= phase_next;
      cnt   <= cnt_next;
    end
  end

  always_ff @(posedge clk) begin
    mods <= mods_next;
  end

  assign desc_valid = acc && (n != '0 || term);
  assign desc       = {term, n, chs};

endmodule

// File: hw/rtl/pfr_fifo.sv
// ----------------------------------------------------------------------------
// pfr_fifo: short queue between parser and emitter
// A small register queue that lets the parser and the emitter stall apart.
// ----------------------------------------------------------------------------
module pfr_fifo #(
  parameter int DW    = 8,
  parameter int DEPTH = 2
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          wr,
  input  logic [DW-1:0] wdata,
  input  logic          rd,
  output logic [DW-1:0] rdata,
  output logic          full,
  output logic          empty
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNW = $clog2(DEPTH + 1);

  logic [DW-1:0] mem [DEPTH];
  logic [AW-1:0] wptr, rptr;
  logic [CNW-1:0] count;

  assign full  = (count == CNW'(DEPTH));
  assign empty = (count == '0);
  assign rdata = mem[rptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (wr) begin
        wptr <= (wptr == AW'(DEPTH - 1)) ? '0 : wptr + AW'(1);
      end
      if (rd) begin
        rptr <= (rptr == AW'(DEPTH - 1)) ? '0 : rptr + AW'(1);
      end
      if (wr && !rd) begin
        count <= count + CNW'(1);
      end else if (rd && !wr) begin
        count <= count - CNW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr) begin
      mem[wptr] <= wdata;
    end
  end

endmodule

// File: hw/rtl/pfr_back.sv
// ----------------------------------------------------------------------------
// pfr_back: character emitter
// Takes one group of characters from the queue and hands them out one word
// per cycle as pop allows, then the terminator where the group carries one.
// ----------------------------------------------------------------------------
module pfr_back #(
  parameter int MAX_LEN = 3,
  parameter int CW      = 16
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 q_empty,
  input  logic [((MAX_LEN > 2) ? MAX_LEN : 2) * CW + CW
               + $clog2(((MAX_LEN > 2) ? MAX_LEN : 2) + 2) : 0] q_data,
  output logic                                 q_pop,
  input  logic                                 pop,
  output logic                                 empty,
  output logic [pfr_pkg::CHAR_W-1:0]           out_char,
  output logic                                 out_last
);

  localparam int NHELD = (MAX_LEN > 2) ? MAX_LEN : 2;
  localparam int NSLOT = NHELD + 1;
  localparam int NW    = $clog2(NSLOT + 1);
  localparam int IW    = $clog2(NSLOT);
  localparam int PW    = pfr_pkg::CHAR_W;

  logic cur_valid;
  logic [NW-1:0] pos;
  logic cur_term;
  logic [NW-1:0] cur_n;
  logic [NSLOT-1:0][CW-1:0] cur_chs;
  logic take, last_word, load, in_chars;

  assign in_chars  = (pos < cur_n);
  assign last_word = cur_term ? (pos == cur_n) : (pos == cur_n - NW'(1));
  assign take      = pop && cur_valid;
  assign load      = !q_empty && (!cur_valid || (take && last_word));
  assign q_pop     = load;

  assign empty    = !cur_valid;
  assign out_char = in_chars ? PW'(cur_chs[pos[IW-1:0]]) : '0;
  assign out_last = !in_chars;

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_valid <= 1'b0;
      pos       <= '0;
    end else if (load) begin
      cur_valid <= 1'b1;
      pos       <= '0;
    end else if (take && last_word) begin
      cur_valid <= 1'b0;
    end else if (take) begin
      pos <= pos + NW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      {cur_term, cur_n, cur_chs} <= q_data;
    end
  end

endmodule

// File: hw/rtl/printf_format_respeller_top.sv
// A word's group is queued and then loaded into the emitter before its first word shows.
// Throughput: one input word per cycle while each gives a single result word and the
// receiver pops every cycle; a longer expansion holds the emitter until all are popped.
// The emitter, one result word per cycle while pop is high, sets the sustained rate.
// Reset clears the parser phase, the queue, the emitter and wide_mode; no clearing pass.
// ----------------------------------------------------------------------------
// printf_format_respeller_top: format string respeller
// Rewrites length modifiers and string conversions of a format string, one
// character per word, with a two-entry queue between parser and emitter.
// ----------------------------------------------------------------------------
module printf_format_respeller_top #(
  parameter int MAX_LENGTH_CHARS = 3,
  parameter int CHAR_WIDTH       = 16
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_write,
  input  logic                       cfg_data,
  input  logic                       push,
  output logic                       full,
  input  logic [pfr_pkg::CHAR_W-1:0] in_char,
  input  logic                       in_last,
  output logic                       empty,
  input  logic                       pop,
  output logic [pfr_pkg::CHAR_W-1:0] out_char,
  output logic                       out_last
);

  localparam int PW    = pfr_pkg::CHAR_W;
  localparam int CW    = (CHAR_WIDTH < PW) ? CHAR_WIDTH : PW;
  localparam int NHELD = (MAX_LENGTH_CHARS > 2) ? MAX_LENGTH_CHARS : 2;
  localparam int DW    = NHELD * CW + CW + $clog2(NHELD + 2) + 1;

  logic wide_mode;
  logic acc;
  logic q_push, q_pop, q_full, q_empty;
  logic [DW-1:0] q_wdata, q_rdata;

  always_ff @(posedge clk) begin
    if (rst) begin
      wide_mode <= 1'b0;
    end else if (cfg_write) begin
      wide_mode <= cfg_data;
    end
  end

  assign full = q_full;
  assign acc  = push && !q_full;

  pfr_front #(
    .MAX_LEN (MAX_LENGTH_CHARS),
    .CW      (CW)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .wide_mode  (wide_mode),
    .acc        (acc),
    .in_char    (in_char),
    .in_last    (in_last),
    .desc_valid (q_push),
    .desc       (q_wdata)
  );

  pfr_fifo #(
    .DW    (DW),
    .DEPTH (2)
  ) u_fifo (
    .clk   (clk),
    .rst   (rst),
    .wr    (q_push),
    .wdata (q_wdata),
    .rd    (q_pop),
    .rdata (q_rdata),
    .full  (q_full),
    .empty (q_empty)
  );

  pfr_back #(
    .MAX_LEN (MAX_LENGTH_CHARS),
    .CW      (CW)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .q_empty  (q_empty),
    .q_data   (q_rdata),
    .q_pop    (q_pop),
    .pop      (pop),
    .empty    (empty),
    .out_char (out_char),
    .out_last (out_last)
  );

`ifndef ASSERT_OFF
  a_push_only_on_accept: assert property (@(posedge clk) disable iff (rst)
    q_push |-> (push && !full))
    else $error("queue written without an accepted word");

  a_no_pop_when_empty: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> !q_empty)
    else $error("queue read while empty");

  a_terminator_zero: assert property (@(posedge clk) disable iff (rst)
    (!empty && out_last) |-> (out_char == '0))
    else $error("terminator word carries a non-zero character");

  a_empty_after_reset: assert property (@(posedge clk)
    rst |=> empty)
    else $error("result side not empty after reset");
`endif

endmodule

// File: sim/printf_format_respeller_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// printf_format_respeller_top_tb: self-checking bench for the format respeller
// Feeds format strings word by word, predicts every output word in a scoreboard
// and compares each popped word field by field, under several idling patterns.
// ----------------------------------------------------------------------------
module printf_format_respeller_top_tb;

  localparam int CHAR_W           = pfr_pkg::CHAR_W;
  localparam int MAX_LENGTH_CHARS = 3;
  localparam int LIMIT            = 400000;

  typedef struct packed {
    logic [CHAR_W-1:0] ch;
    logic              last;
  } out_word_t;

  class respell_scoreboard;
    bit                wide;
    pfr_pkg::phase_t   phase;
    logic [7:0]        held [5];
    int unsigned       count;
    out_word_t         expected_words [$];
    int unsigned       errors;

    function void clear();
      wide = 1'b0;
      phase = pfr_pkg::PH_LIT;
      count = 0;
      foreach (held[i]) held[i] = 8'h00;
      expected_words.delete();
    endfunction

    function void emit(logic [CHAR_W-1:0] c, logic l);
      out_word_t w;
      w.ch = c;
      w.last = l;
      expected_words.push_back(w);
    endfunction

    function bit is_flag(logic [CHAR_W-1:0] c);
      return c == pfr_pkg::CH_MINUS || c == pfr_pkg::CH_PLUS || c == pfr_pkg::CH_SPACE ||
             c == pfr_pkg::CH_HASH || c == pfr_pkg::CH_0 || c == pfr_pkg::CH_APOS;
    endfunction

    function bit is_width(logic [CHAR_W-1:0] c);
      return (c >= pfr_pkg::CH_0 && c <= pfr_pkg::CH_9) || c == pfr_pkg::CH_STAR;
    endfunction

    function bit is_length(logic [CHAR_W-1:0] c);
      return c == pfr_pkg::CH_H || c == pfr_pkg::CH_L || c == pfr_pkg::CH_UPPER_L ||
             c == pfr_pkg::CH_J || c == pfr_pkg::CH_Z || c == pfr_pkg::CH_T ||
             c == pfr_pkg::CH_W;
    endfunction

    function void literal(logic [CHAR_W-1:0] c);
      emit(c, 1'b0);
      phase = (c == pfr_pkg::CH_PCT) ? pfr_pkg::PH_PCT : pfr_pkg::PH_LIT;
    endfunction

    function void convert(logic [CHAR_W-1:0] c);
      logic [7:0] lead;
      bit         wide_arg;
      lead = (count != 0) ? held[0] : 8'h00;
      if (c == pfr_pkg::CH_UPPER_S || c == pfr_pkg::CH_UPPER_C) begin
        wide_arg = !wide;
      end else if (c == pfr_pkg::CH_LOWER_S || c == pfr_pkg::CH_LOWER_C) begin
        if (lead == pfr_pkg::CH_H) wide_arg = 1'b0;
        else if (lead == pfr_pkg::CH_L || lead == pfr_pkg::CH_W) wide_arg = 1'b1;
        else wide_arg = wide;
      end else begin
        for (int i = 0; i < count; i++)
          emit(CHAR_W'((held[i] == pfr_pkg::CH_W) ? pfr_pkg::CH_L : held[i]), 1'b0);
        emit(c, 1'b0);
        phase = pfr_pkg::PH_LIT;
        count = 0;
        return;
      end
      if (wide_arg) emit(CHAR_W'(pfr_pkg::CH_L), 1'b0);
      emit(CHAR_W'((c == pfr_pkg::CH_UPPER_S || c == pfr_pkg::CH_LOWER_S) ?
                   pfr_pkg::CH_LOWER_S : pfr_pkg::CH_LOWER_C), 1'b0);
      phase = pfr_pkg::PH_LIT;
      count = 0;
    endfunction

    function void length_start(logic [CHAR_W-1:0] c);
      count = 0;
      if (c == pfr_pkg::CH_I) begin
        phase = pfr_pkg::PH_HI;
      end else if (is_length(c)) begin
        held[0] = c[7:0];
        count = 1;
        phase = pfr_pkg::PH_LEN;
      end else begin
        convert(c);
      end
    endfunction

    function void width_stage(logic [CHAR_W-1:0] c);
      if (is_width(c)) begin
        emit(c, 1'b0);
        phase = pfr_pkg::PH_WIDTH;
      end else if (c == pfr_pkg::CH_DOT) begin
        emit(c, 1'b0);
        phase = pfr_pkg::PH_PREC;
      end else begin
        length_start(c);
      end
    endfunction

    function void flags_stage(logic [CHAR_W-1:0] c);
      if (is_flag(c)) begin
        emit(c, 1'b0);
        phase = pfr_pkg::PH_FLAGS;
      end else begin
        width_stage(c);
      end
    endfunction

    function void respell_char(logic [CHAR_W-1:0] c);
      case (phase)
        pfr_pkg::PH_PCT: begin
          if (c == pfr_pkg::CH_PCT) begin
            emit(c, 1'b0);
            phase = pfr_pkg::PH_LIT;
          end else begin
            flags_stage(c);
          end
        end
        pfr_pkg::PH_FLAGS: flags_stage(c);
        pfr_pkg::PH_WIDTH: width_stage(c);
        pfr_pkg::PH_PREC: begin
          if (is_width(c)) emit(c, 1'b0);
          else length_start(c);
        end
        pfr_pkg::PH_LEN: begin
          if (count < MAX_LENGTH_CHARS && is_length(c)) begin
            held[count] = c[7:0];
            count++;
          end else begin
            convert(c);
          end
        end
        pfr_pkg::PH_HI: begin
          if (c == pfr_pkg::CH_6) phase = pfr_pkg::PH_HI6;
          else if (c == pfr_pkg::CH_3) phase = pfr_pkg::PH_HI3;
          else begin
            emit(CHAR_W'(pfr_pkg::CH_I), 1'b0);
            literal(c);
          end
        end
        pfr_pkg::PH_HI6: begin
          if (c == pfr_pkg::CH_4) begin
            held[0] = pfr_pkg::CH_L;
            held[1] = pfr_pkg::CH_L;
            count = 2;
            phase = pfr_pkg::PH_CONV;
          end else begin
            emit(CHAR_W'(pfr_pkg::CH_I), 1'b0);
            emit(CHAR_W'(pfr_pkg::CH_6), 1'b0);
            literal(c);
          end
        end
        pfr_pkg::PH_HI3: begin
          if (c == pfr_pkg::CH_2) begin
            count = 0;
            phase = pfr_pkg::PH_CONV;
          end else begin
            emit(CHAR_W'(pfr_pkg::CH_I), 1'b0);
            emit(CHAR_W'(pfr_pkg::CH_3), 1'b0);
            literal(c);
          end
        end
        pfr_pkg::PH_CONV: convert(c);
        default: literal(c);
      endcase
    endfunction

    // The end of a string flushes whatever the directive still holds, as written.
    function void end_string();
      case (phase)
        pfr_pkg::PH_HI: emit(CHAR_W'(pfr_pkg::CH_I), 1'b0);
        pfr_pkg::PH_HI6: begin
          emit(CHAR_W'(pfr_pkg::CH_I), 1'b0);
          emit(CHAR_W'(pfr_pkg::CH_6), 1'b0);
        end
        pfr_pkg::PH_HI3: begin
          emit(CHAR_W'(pfr_pkg::CH_I), 1'b0);
          emit(CHAR_W'(pfr_pkg::CH_3), 1'b0);
        end
        pfr_pkg::PH_LEN, pfr_pkg::PH_CONV: begin
          for (int i = 0; i < count; i++) emit(CHAR_W'(held[i]), 1'b0);
        end
        default: ;
      endcase
      emit('0, 1'b1);
      phase = pfr_pkg::PH_LIT;
      count = 0;
    endfunction

    function void note_char(logic [CHAR_W-1:0] c, logic l);
      respell_char(c);
      if (l) end_string();
    endfunction

    function void report(string what, out_word_t exp_w, logic [CHAR_W-1:0] ch, logic l);
      errors++;
      if (errors <= 10)
        $display("%0t: %s: expected char %h last %b, got char %h last %b",
                 $realtime, what, exp_w.ch, exp_w.last, ch, l);
    endfunction

    function void check_word(logic [CHAR_W-1:0] ch, logic l);
      out_word_t w;
      if (expected_words.size() == 0) begin
        w = '0;
        report("unexpected word", w, ch, l);
      end else begin
        w = expected_words.pop_front();
        if (w.ch !== ch || w.last !== l) report("word mismatch", w, ch, l);
      end
    endfunction

    function int unsigned pending();
      return expected_words.size();
    endfunction
  endclass

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              cfg_write = 1'b0;
  logic              cfg_data = 1'b0;
  logic              push = 1'b0;
  logic              full;
  logic [CHAR_W-1:0] in_char = '0;
  logic              in_last = 1'b0;
  logic              empty;
  logic              pop = 1'b0;
  logic [CHAR_W-1:0] out_char;
  logic              out_last;

  logic              hold_on = 1'b0;
  int                send_idle = 0;
  int                recv_stall = 0;
  int                items_sent = 0;
  int                cycle_count = 0;
  respell_scoreboard sb;

  printf_format_respeller_top i_dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_write(cfg_write),
    .cfg_data (cfg_data),
    .push     (push),
    .full     (full),
    .in_char  (in_char),
    .in_last  (in_last),
    .empty    (empty),
    .pop      (pop),
    .out_char (out_char),
    .out_last (out_last)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty) sb.check_word(out_char, out_last);
      pop <= !hold_on && ($urandom_range(99) >= recv_stall);
    end
  end

  task automatic send_word(logic [CHAR_W-1:0] c, logic l);
    while ($urandom_range(99) < send_idle) begin
      push <= 1'b0;
      @(posedge clk);
    end
    push <= 1'b1;
    in_char <= c;
    in_last <= l;
    @(posedge clk);
    while (full) @(posedge clk);
    sb.note_char(c, l);
    items_sent++;
  endtask

  task automatic send_text(string s, bit ends);
    for (int i = 0; i < s.len(); i++)
      send_word({8'h00, s[i]}, ends && i == s.len() - 1);
  endtask

  function automatic logic [CHAR_W-1:0] pick(string s);
    return {8'h00, s[$urandom_range(s.len() - 1)]};
  endfunction

  task automatic drain();
    push <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_wide(bit v);
    cfg_write <= 1'b1;
    cfg_data <= v;
    @(posedge clk);
    cfg_write <= 1'b0;
    sb.wide = v;
  endtask

  // Mostly well-formed directives with random content, some plain text and noise.
  task automatic send_random_chunk();
    logic [CHAR_W-1:0] text [$];
    int                kind;
    int                sel;
    kind = $urandom_range(99);
    if (kind < 65) begin
      text.push_back(CHAR_W'(pfr_pkg::CH_PCT));
      repeat ($urandom_range(2)) text.push_back(pick("-+ #0'"));
      repeat ($urandom_range(2)) text.push_back(pick("0123456789*"));
      if ($urandom_range(2) == 0) begin
        text.push_back(CHAR_W'(pfr_pkg::CH_DOT));
        repeat ($urandom_range(2)) text.push_back(pick("0123456789*"));
      end
      sel = $urandom_range(9);
      if (sel >= 3 && sel <= 5) begin
        repeat ($urandom_range(4, 1)) text.push_back(pick("hlLjztw"));
      end else if (sel == 6 || sel == 9) begin
        text.push_back(CHAR_W'(pfr_pkg::CH_I));
        text.push_back(CHAR_W'(pfr_pkg::CH_6));
        text.push_back(CHAR_W'(pfr_pkg::CH_4));
        if (sel == 9) text.push_back(pick("hlw"));
      end else if (sel == 7) begin
        text.push_back(CHAR_W'(pfr_pkg::CH_I));
        text.push_back(CHAR_W'(pfr_pkg::CH_3));
        text.push_back(CHAR_W'(pfr_pkg::CH_2));
      end else if (sel == 8) begin
        text.push_back(CHAR_W'(pfr_pkg::CH_I));
        case ($urandom_range(2))
          1: text.push_back(CHAR_W'(pfr_pkg::CH_6));
          2: text.push_back(CHAR_W'(pfr_pkg::CH_3));
          default: ;
        endcase
      end
      sel = $urandom_range(9);
      if (sel < 4) text.push_back(pick("sScC"));
      else if (sel < 8) text.push_back(pick("diuxXpnfeg%"));
      else if (sel == 8) text.push_back(CHAR_W'($urandom_range(65535, 1)));
      else text.push_back(pick("hlwI6%"));
    end else if (kind < 90) begin
      repeat ($urandom_range(4, 1))
        text.push_back(CHAR_W'(($urandom_range(2) != 0) ? $urandom_range(126, 32)
                                                         : $urandom_range(65535, 1)));
    end else begin
      repeat ($urandom_range(3, 1)) text.push_back(CHAR_W'($urandom_range(65535, 1)));
    end
    foreach (text[i]) send_word(text[i], $urandom_range(9) == 0);
  endtask

  initial begin
    int target;
    int idle_pct [4];
    int stall_pct [4];
    sb = new;
    sb.clear();
    idle_pct = '{0, 88, 0, 7};
    stall_pct = '{0, 0, 88, 7};
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    write_wide(1'b0);
    send_text("%I64h%I32x", 1'b0);
    send_text("%Iz%I6%ws", 1'b1);
    send_text("%hlLq%wl", 1'b1);
    send_text("%I3", 1'b1);
    send_word(CHAR_W'(pfr_pkg::CH_PCT), 1'b0);
    send_word(16'hFFFF, 1'b0);
    send_word(16'h0001, 1'b1);
    drain();
    write_wide(1'b1);
    send_text("%S%C%hc%s", 1'b1);
    drain();

    // The receiver holds off long enough for the block to fill and stall its input.
    fork
      begin
        hold_on <= 1'b1;
        repeat (250) @(posedge clk);
        hold_on <= 1'b0;
      end
    join_none
    target = items_sent + 40;
    while (items_sent < target) send_random_chunk();
    drain();

    for (int p = 0; p < 4; p++) begin
      send_idle = idle_pct[p];
      recv_stall = stall_pct[p];
      write_wide(p[0] ^ 1'b1);
      target = items_sent + 95;
      while (items_sent < target) send_random_chunk();
      drain();
    end

    sb.errors += sb.pending();
    if (sb.errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// File: filelist.f
hw/rtl/pfr_pkg.sv
hw/rtl/pfr_front.sv
hw/rtl/pfr_fifo.sv
hw/rtl/pfr_back.sv
hw/rtl/printf_format_respeller_top.sv
sim/printf_format_respeller_top_tb.sv
